/* sv/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants for the sprite pixel scan block
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	typedef enum logic [1:0] {
		OP_ATTR_WR    = 2'd0,
		OP_PAT_WR     = 2'd1,
		OP_QUERY      = 2'd2,
		OP_LINE_START = 2'd3
	} opcode_t;

	localparam logic [1:0] PRIO_NONE  = 2'd0;
	localparam logic [1:0] PRIO_FRONT = 2'd1;
	localparam logic [1:0] PRIO_BACK  = 2'd2;

	localparam logic [5:0] NUM_NONE = 6'd1;

	localparam int ATTR_PRIO  = 5;
	localparam int ATTR_HFLIP = 6;
	localparam int ATTR_VFLIP = 7;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  attr_index;
		logic [12:0] pattern_address;
		logic [7:0]  write_data;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} req_t;

	typedef struct packed {
		logic [1:0] priority_code;
		logic [1:0] sprite_pixel;
		logic [1:0] palette_id;
		logic [5:0] sprite_number;
		logic [7:0] match_count;
	} rsp_t;

	// one sprite entry, byte 0 in the low lane
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] attr;
		logic [7:0] tile;
		logic [7:0] y;
	} sprite_row_t;

	typedef struct packed {
		logic       en;
		logic [7:0] index;
		logic [7:0] data;
	} attr_wr_t;

	typedef struct packed {
		logic        en;
		logic [12:0] addr;
		logic [7:0]  data;
	} pat_wr_t;

endpackage

`default_nettype wire

/* sv/sps_attr_ram.sv */
// ----------------------------------------------------------------------------
// sps_attr_ram
// sprite attribute store, 64 rows of four byte lanes, per-byte valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module sps_attr_ram (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sps_pkg::attr_wr_t   wr,
	input  wire logic [5:0]          raddr,
	output sps_pkg::sprite_row_t     rdata
);

	logic [31:0]  mem [64];
	logic [255:0] vld_q;
	logic [31:0]  rd_q;
	logic [3:0]   rdv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.index] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q <= '0;
		end else begin
			rdv_q <= vld_q[{raddr, 2'b00} +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.index[7:2]][{wr.index[1:0], 3'b000} +: 8] <= wr.data;
		end
		rd_q <= mem[raddr];
	end

	// bytes never written read as zero
	assign rdata = sps_pkg::sprite_row_t'(rd_q & {{8{rdv_q[3]}}, {8{rdv_q[2]}},
		{8{rdv_q[1]}}, {8{rdv_q[0]}}});

endmodule

`default_nettype wire

/* sv/sps_pat_ram.sv */
// ----------------------------------------------------------------------------
// sps_pat_ram
// 8 KB pattern store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sps_pat_ram (
	input  wire logic               clk,
	input  wire sps_pkg::pat_wr_t   wr,
	input  wire logic [12:0]        raddr,
	output logic [7:0]              rdata
);

	logic [7:0] mem [8192];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/sprite_pixel_scan_core.sv */
// ----------------------------------------------------------------------------
// sprite_pixel_scan_core
// sprite pixel evaluation over a 64-entry attribute store and pattern store
//
// channel   signals                    beat
// req       req_valid / req_stall      one write, query or line start
// rsp       rsp_valid / rsp_stall      one result per request beat
// cfg       cfg_valid / cfg_ready      pattern table select bit
//
// writes and line starts go from accept via ST_DONE to the result register
// a query passes through ST_CHK for each sprite scanned, then ST_DONE
// each overlap adds ST_PLO and ST_PHI for the two reads of the pattern port
// no clearing pass after reset, attribute bytes carry their own valid bits
// a held result does not block the next request beat
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_pixel_scan_core #(
	parameter int SPRITE_COUNT = 64,
	parameter int TABLE_OFFSET = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire sps_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output sps_pkg::rsp_t        rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_PLO,
		ST_PHI,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic                 sel_q;
	logic [7:0]           cnt_q;
	logic [7:0]           x_q;
	logic [7:0]           y_q;
	logic [5:0]           idx_q;
	logic [1:0]           prio_q;
	logic [1:0]           pix_q;
	logic [1:0]           pal_q;
	logic [5:0]           num_q;
	logic                 back_q;
	logic [2:0]           col_q;
	logic [12:0]          hi_addr_q;
	logic [7:0]           pat_lo_q;
	logic                 rsp_valid_q;
	sps_pkg::rsp_t        rsp_q;

	sps_pkg::attr_wr_t    attr_wr;
	sps_pkg::pat_wr_t     pat_wr;
	sps_pkg::sprite_row_t row;
	logic [5:0]           attr_raddr;
	logic [12:0]          pat_raddr;
	logic [7:0]           pat_rd;
	logic                 accept;
	logic                 ovl;
	logic [2:0]           tx;
	logic [2:0]           ty;
	logic [12:0]          base;
	logic [12:0]          lo_addr;
	logic                 last;
	logic [5:0]           idx_nxt;
	logic [1:0]           pix_nxt;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign attr_wr.en    = accept && (req.opcode == sps_pkg::OP_ATTR_WR);
	assign attr_wr.index = req.attr_index;
	assign attr_wr.data  = req.write_data;
	assign pat_wr.en     = accept && (req.opcode == sps_pkg::OP_PAT_WR);
	assign pat_wr.addr   = req.pattern_address;
	assign pat_wr.data   = req.write_data;

	assign idx_nxt = idx_q + 6'd1;
	assign last    = (idx_q == 6'(SPRITE_COUNT - 1));

	always_comb begin
		case (state_q)
			ST_CHK, ST_PHI: attr_raddr = idx_nxt;
			default:        attr_raddr = '0;
		endcase
	end

	// overlap without wrap at the right and bottom edges
	always_comb begin
		ovl = ({1'b0, x_q} >= {1'b0, row.x}) && ({1'b0, x_q} < ({1'b0, row.x} + 9'd8))
			&& ({1'b0, y_q} >= {1'b0, row.y}) && ({1'b0, y_q} < ({1'b0, row.y} + 9'd8));
		tx = x_q[2:0] - row.x[2:0];
		ty = y_q[2:0] - row.y[2:0];
		if (row.attr[sps_pkg::ATTR_HFLIP]) begin
			tx = ~tx;
		end
		if (row.attr[sps_pkg::ATTR_VFLIP]) begin
			ty = ~ty;
		end
		base    = sel_q ? 13'(TABLE_OFFSET) : 13'd0;
		lo_addr = base + {1'b0, row.tile, 4'b0000} + {10'd0, ty};
	end

	assign pat_raddr = (state_q == ST_CHK) ? lo_addr : hi_addr_q;
	assign pix_nxt   = {pat_rd[col_q], pat_lo_q[col_q]};

	sps_attr_ram u_attr (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (attr_wr),
		.raddr  (attr_raddr),
		.rdata  (row)
	);

	sps_pat_ram u_pat (
		.clk   (clk),
		.wr    (pat_wr),
		.raddr (pat_raddr),
		.rdata (pat_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sel_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						x_q    <= req.pixel_x;
						y_q    <= req.pixel_y - 8'd1;
						idx_q  <= '0;
						prio_q <= sps_pkg::PRIO_NONE;
						pix_q  <= '0;
						pal_q  <= '0;
						num_q  <= sps_pkg::NUM_NONE;
						if (req.opcode == sps_pkg::OP_LINE_START) begin
							cnt_q <= '0;
						end
						state_q <= (req.opcode == sps_pkg::OP_QUERY) ? ST_CHK : ST_DONE;
					end
				end
				ST_CHK: begin
					if (ovl) begin
						pal_q     <= row.attr[1:0];
						back_q    <= row.attr[sps_pkg::ATTR_PRIO];
						col_q     <= ~tx;
						hi_addr_q <= lo_addr + 13'd8;
						state_q   <= ST_PLO;
					end else if (last) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				ST_PLO: begin
					pat_lo_q <= pat_rd;
					state_q  <= ST_PHI;
				end
				ST_PHI: begin
					pix_q <= pix_nxt;
					num_q <= idx_q;
					cnt_q <= cnt_q + 8'd1;
					if (pix_nxt != 2'd0) begin
						prio_q  <= back_q ? sps_pkg::PRIO_BACK : sps_pkg::PRIO_FRONT;
						state_q <= ST_DONE;
					end else if (last) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= ST_CHK;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.priority_code <= prio_q;
						rsp_q.sprite_pixel  <= pix_q;
						rsp_q.palette_id    <= pal_q;
						rsp_q.sprite_number <= num_q;
						rsp_q.match_count   <= cnt_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_opaque_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.priority_code != sps_pkg::PRIO_NONE) |-> rsp.sprite_pixel != 2'd0)
		else $error("opaque result with transparent pixel");

	a_none_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.priority_code == sps_pkg::PRIO_NONE) |-> rsp.sprite_pixel == 2'd0)
		else $error("transparent result with nonzero pixel");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.opcode == sps_pkg::OP_QUERY) |=> req_stall)
		else $error("request taken while a query is scanning");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK || state_q == ST_PLO || state_q == ST_PHI)
		|-> !attr_wr.en && !pat_wr.en)
		else $error("store written during a scan");

	a_line_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.opcode == sps_pkg::OP_LINE_START) |=> cnt_q == 8'd0)
		else $error("line start left the match counter set");

endmodule

`default_nettype wire

/* tb/sprite_eval_pkg.sv */
// ----------------------------------------------------------------------------
// sprite_eval_pkg
// expected-result tracking for the sprite pixel scan testbench: a copy of the
// attribute and pattern stores, the overlap counter and the table select bit,
// updated on every accepted request beat and compared with every result beat
// ----------------------------------------------------------------------------
package sprite_eval_pkg;

	import sps_pkg::*;

	localparam int SPRITES        = 64;
	localparam int PAT_TABLE_BASE = 4096;

	class sprite_eval_board;
		logic [7:0] sprite_bytes [256];
		logic [7:0] pattern_bytes [8192];
		logic [7:0] overlaps;
		bit         high_table;
		rsp_t       pending_pixels [$];
		int         mismatches;
		int         beats_checked;
		int         queries;
		int         opaque_hits;
		int         overlap_total;

		function new();
			foreach (sprite_bytes[i]) sprite_bytes[i] = 8'h00;
			foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
			overlaps      = 8'h00;
			high_table    = 1'b0;
			mismatches    = 0;
			beats_checked = 0;
			queries       = 0;
			opaque_hits   = 0;
			overlap_total = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t        want;
			int          qx, qy, sx, sy, tx, ty, base, s;
			logic [7:0]  at, lo, hi;
			logic [12:0] row_addr;
			want.priority_code = PRIO_NONE;
			want.sprite_pixel  = 2'd0;
			want.palette_id    = 2'd0;
			want.sprite_number = NUM_NONE;
			case (r.opcode)
				OP_ATTR_WR: sprite_bytes[r.attr_index] = r.write_data;
				OP_PAT_WR: pattern_bytes[r.pattern_address] = r.write_data;
				OP_LINE_START: overlaps = 8'h00;
				default: begin
					queries++;
					qx = int'(r.pixel_x);
					qy = (int'(r.pixel_y) + 255) % 256;
					base = high_table ? PAT_TABLE_BASE : 0;
					for (s = 0; s < SPRITES; s++) begin
						sy = int'(sprite_bytes[4 * s]);
						sx = int'(sprite_bytes[4 * s + 3]);
						// no wrap at the right or bottom edge
						if (qx < sx || qx >= sx + 8 || qy < sy || qy >= sy + 8)
							continue;
						at = sprite_bytes[4 * s + 2];
						tx = at[ATTR_HFLIP] ? 7 - (qx - sx) : qx - sx;
						ty = at[ATTR_VFLIP] ? 7 - (qy - sy) : qy - sy;
						row_addr = 13'(base + 16 * int'(sprite_bytes[4 * s + 1]) + ty);
						lo = pattern_bytes[row_addr];
						hi = pattern_bytes[13'(row_addr + 13'd8)];
						want.sprite_pixel  = {hi[7 - tx], lo[7 - tx]};
						want.palette_id    = at[1:0];
						want.sprite_number = 6'(s);
						overlaps++;
						overlap_total++;
						if (want.sprite_pixel != 2'd0) begin
							want.priority_code = at[ATTR_PRIO] ? PRIO_BACK : PRIO_FRONT;
							opaque_hits++;
							break;
						end
					end
				end
			endcase
			want.match_count = overlaps;
			pending_pixels.push_back(want);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("beat %0d %s: got %0h, want %0h",
					beats_checked, name, got, want));
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending: %p", got));
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("priority_code", 8'(got.priority_code), 8'(want.priority_code));
			compare_field("sprite_pixel", 8'(got.sprite_pixel), 8'(want.sprite_pixel));
			compare_field("palette_id", 8'(got.palette_id), 8'(want.palette_id));
			compare_field("sprite_number", 8'(got.sprite_number), 8'(want.sprite_number));
			compare_field("match_count", got.match_count, want.match_count);
			beats_checked++;
		endtask

		task report_leftover();
			if (pending_pixels.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
		endtask
	endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for sprite_pixel_scan_core: fills the pattern bytes of the tiles
// in use, runs short directed cases on stacked, flipped, edge and wrapping
// sprites, then random sprite placements with queries aimed inside them,
// under random idling on both channels and several pattern table settings
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;
	import sprite_eval_pkg::*;

	localparam int SCAN_TAIL    = 2 + 3 * SPRITES + 8;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BEATS = 450;
	localparam int PHASES       = 6;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data  = 1'b0;

	sprite_eval_board board = new();

	int req_calm    = 0;
	int rsp_calm    = 0;
	int req_gap     = 1;
	int cycles      = 0;
	int cfg_writes  = 0;
	bit [1:0] tables_seen = 2'b00;

	sprite_pixel_scan_core #(
		.SPRITE_COUNT(SPRITES),
		.TABLE_OFFSET(PAT_TABLE_BASE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** sprite_pixel_scan_core: FAILED **");
			$finish;
		end
	end

	// idle cycles before the next beat, with occasional runs of no idling
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// sprites only ever use these four tiles
	function automatic int tile_of(input int slot);
		return (slot < 2) ? slot : slot + 252;
	endfunction

	function automatic int pick_tile();
		return tile_of($urandom_range(0, 3));
	endfunction

	function automatic req_t make_req(opcode_t op);
		req_t r;
		r.opcode          = op;
		r.attr_index      = 8'($urandom);
		r.pattern_address = 13'($urandom);
		r.write_data      = 8'($urandom);
		r.pixel_x         = 8'($urandom);
		r.pixel_y         = 8'($urandom);
		return r;
	endfunction

	task automatic send_beat(input req_t r);
		repeat (req_gap) @(posedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		board.note_request(r);
		req_gap = draw_gap(req_calm);
		if (req_gap != 0)
			req_valid <= 1'b0;
	endtask

	task automatic put_attr(input int idx, input int data);
		req_t r;
		r = make_req(OP_ATTR_WR);
		r.attr_index = 8'(idx);
		r.write_data = 8'(data);
		send_beat(r);
	endtask

	task automatic put_pattern(input int addr, input int data);
		req_t r;
		r = make_req(OP_PAT_WR);
		r.pattern_address = 13'(addr);
		r.write_data      = 8'(data);
		send_beat(r);
	endtask

	task automatic ask_pixel(input int x, input int y);
		req_t r;
		r = make_req(OP_QUERY);
		r.pixel_x = 8'(x);
		r.pixel_y = 8'(y);
		send_beat(r);
	endtask

	task automatic start_line();
		send_beat(make_req(OP_LINE_START));
	endtask

	task automatic drain_results();
		if (req_gap == 0) begin
			req_valid <= 1'b0;
			req_gap = 1;
		end
		while (board.pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_table_select(input bit sel);
		drain_results();
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sel;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		board.high_table = sel;
		cfg_writes++;
		tables_seen[sel] = 1'b1;
	endtask

	initial begin : result_sink
		int gap;
		forever begin
			gap = draw_gap(rsp_calm);
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (rsp_valid !== 1'b1);
			board.check_result(rsp);
		end
	end

	initial begin : stimulus
		int   a, ph, pick, s, k, n, sent;
		int   cx [4];
		int   cy [4];
		bit   held;
		bit   sel;
		req_t r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_table_select(1'b0);

		// every byte of the tiles in use, in both tables, gets written before any query
		for (a = 0; a < 128; a++)
			put_pattern((a / 64) * PAT_TABLE_BASE + 16 * tile_of((a / 16) % 4) + a % 16,
				$urandom_range(0, 255));

		// all 64 sprites sit at the origin with tile 0 after reset
		put_pattern(0, 0);
		put_pattern(8, 0);
		repeat (4) ask_pixel(0, 1);
		ask_pixel(7, 8);
		ask_pixel(0, 0);
		start_line();
		put_attr(20, 250);
		put_attr(21, 255);
		put_attr(22, 8'hE3);
		put_attr(23, 252);
		ask_pixel(255, 255);
		put_pattern(0, 8'h80);
		ask_pixel(0, 1);
		put_attr(2, 8'h20);
		ask_pixel(0, 1);
		put_attr(2, 8'h60);
		ask_pixel(0, 1);
		write_table_select(1'b1);
		ask_pixel(0, 1);
		put_attr(255, 255);
		put_pattern(8191, 255);
		ask_pixel(255, 1);

		held = 1'b0;
		for (ph = 0; ph < PHASES; ph++) begin
			sel = (ph == 3 || ph == 5) ? 1'($urandom_range(0, 1)) : 1'(ph % 2);
			write_table_select(sel);
			for (k = 0; k < 4; k++) begin
				cx[k] = $urandom_range(0, 255);
				cy[k] = $urandom_range(0, 255);
			end
			cx[0] = 248;
			cy[1] = 249;
			sent = 0;
			while (sent < RANDOM_BEATS / PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					s = $urandom_range(0, SPRITES - 1);
					k = $urandom_range(0, 3);
					put_attr(4 * s, cy[k] + $urandom_range(0, 7));
					put_attr(4 * s + 1, pick_tile());
					put_attr(4 * s + 2, $urandom_range(0, 255));
					put_attr(4 * s + 3, cx[k] + $urandom_range(0, 7));
					sent += 4;
				end else if (pick < 75) begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						s = $urandom_range(0, SPRITES - 1);
						ask_pixel(int'(board.sprite_bytes[4 * s + 3]) + $urandom_range(0, 7),
							int'(board.sprite_bytes[4 * s]) + $urandom_range(1, 8));
					end
					sent += n;
				end else if (pick < 80) begin
					start_line();
					sent++;
				end else if (pick < 90) begin
					put_pattern($urandom_range(0, 8191), $urandom_range(0, 255));
					sent++;
				end else begin
					r = make_req(opcode_t'($urandom_range(0, 3)));
					if (r.opcode == OP_ATTR_WR && r.attr_index[1:0] == 2'd1)
						r.write_data = 8'(pick_tile());
					send_beat(r);
					sent++;
				end
				if (ph == 2 && !held && sent >= 50) begin
					drain_results();
					held = 1'b1;
				end
			end
		end

		drain_results();
		repeat (SCAN_TAIL) @(posedge clk);
		board.report_leftover();
		$display("checked %0d result beats: %0d pixel queries, %0d sprite overlaps, %0d opaque hits",
			board.beats_checked, board.queries, board.overlap_total, board.opaque_hits);
		$display("pattern table select written %0d times, settings used: %b",
			cfg_writes, tables_seen);
		if (board.mismatches == 0)
			$display("** sprite_pixel_scan_core: PASSED **");
		else
			$display("** sprite_pixel_scan_core: FAILED **");
		$finish;
	end

endmodule
